// ===== hdl/voxel_face_visibility_core_macros.svh =====
// Assertion helpers for the voxel face visibility core.
// Each macro expects clk and rst_n in scope.
`ifndef VOXEL_FACE_VISIBILITY_CORE_MACROS_SVH
`define VOXEL_FACE_VISIBILITY_CORE_MACROS_SVH

// Condition holds at every edge out of reset.
`define VFV_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define VFV_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define VFV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vfv_pkg.sv =====
package vfv_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int MAX_HEIGHT = 16;
  localparam int MAX_LENGTH = 16;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT * MAX_LENGTH;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int COORD_W = 4;
  localparam int ID_W    = 8;
  localparam int SIZE_W  = 5;
  localparam int FACE_N  = 6;
  localparam int CNT_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LENGTH = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int FACE_LEFT   = 0;
  localparam int FACE_RIGHT  = 1;
  localparam int FACE_BOTTOM = 2;
  localparam int FACE_TOP    = 3;
  localparam int FACE_BACK   = 4;
  localparam int FACE_FRONT  = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  localparam logic [ID_W-1:0]   FLOOR_ID   = ID_W'(1);

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   data;
  } ram_wr_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
    logic [ADDR_W-1:0] a;
    a = (ADDR_W'(x) * ADDR_W'(MAX_HEIGHT) + ADDR_W'(y)) * ADDR_W'(MAX_LENGTH)
        + ADDR_W'(z);
    return a;
  endfunction

endpackage

// ===== hdl/vfv_if.sv =====
interface vfv_in_if;
  import vfv_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [COORD_W-1:0] cell_z;
  logic [ID_W-1:0]    new_id;

  modport source(output valid, command, cell_x, cell_y, cell_z, new_id, input ready);
  modport sink(input valid, command, cell_x, cell_y, cell_z, new_id, output ready);
endinterface

interface vfv_out_if;
  import vfv_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   stored_id;
  logic [FACE_N-1:0] face_mask;
  logic [CNT_W-1:0]  face_count;

  modport source(output valid, stored_id, face_mask, face_count, input ready);
  modport sink(input valid, stored_id, face_mask, face_count, output ready);
endinterface

// ===== hdl/voxel_face_visibility_core.sv =====
// Pipeline: an accepted item passes the stage-1 register, the grid read (stage 2) and the result reg.
// Throughput: one item per cycle while out_chan.ready is high and no clearing pass runs; four grid
// copies with two read ports each serve the cell and its six neighbors in the same read.
// Reset: synchronous, active low; grid sizes return to 16 and a clearing pass over all
// 4096 cells rewrites the grid (bottom layer id 1, rest 0) while in_chan.ready is low.
`include "voxel_face_visibility_core_macros.svh"

module voxel_face_visibility_core (
  input  logic                            clk,
  input  logic                            rst_n,
  vfv_in_if.sink                          in_chan,
  vfv_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [vfv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vfv_pkg::SIZE_W-1:0]      cfg_wdata
);
  import vfv_pkg::*;

  localparam int RAM_N = 4;
  localparam int RD_N  = 2 * RAM_N;

  function automatic logic [SIZE_W-1:0] size_use(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] s;
    if (r == '0) s = SIZE_W'(1);
    else if (r > maxv) s = maxv;
    else s = r;
    return s;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c,
                                                     input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] lim;
    lim = size - SIZE_W'(1);
    return ({1'b0, c} >= size) ? lim[COORD_W-1:0] : c;
  endfunction

  // configuration
  logic [SIZE_W-1:0] grid_width_r, grid_height_r, grid_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= SIZE_RESET;
      grid_height_r <= SIZE_RESET;
      grid_length_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        CFG_GRID_LENGTH: grid_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] w_use, h_use, l_use;
  assign w_use = size_use(grid_width_r,  SIZE_W'(MAX_WIDTH));
  assign h_use = size_use(grid_height_r, SIZE_W'(MAX_HEIGHT));
  assign l_use = size_use(grid_length_r, SIZE_W'(MAX_LENGTH));

  // clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_y;

  assign clr_y = (clr_addr_r / ADDR_W'(MAX_LENGTH)) % ADDR_W'(MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(CELL_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // pipeline control
  logic s1_v_r, s2_v_r, out_v_r;
  logic s1_ld, s2_ld, out_ld, in_acc;

  assign out_ld = !out_v_r || out_chan.ready;
  assign s2_ld  = !s2_v_r || out_ld;
  assign s1_ld  = !s1_v_r || s2_ld;
  assign in_chan.ready = s1_ld && !clearing_r;
  assign in_acc = in_chan.valid && in_chan.ready;

  // stage 1: clamped coordinates and boundary flags
  logic               s1_cmd_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [ID_W-1:0]    s1_id_r;
  logic [FACE_N-1:0]  s1_edge_r;

  logic [COORD_W-1:0] x_c, y_c, z_c;
  logic [FACE_N-1:0]  edge_c;

  always_comb begin
    x_c = clamp_coord(in_chan.cell_x, w_use);
    y_c = clamp_coord(in_chan.cell_y, h_use);
    z_c = clamp_coord(in_chan.cell_z, l_use);
    edge_c[FACE_LEFT]   = (x_c == '0);
    edge_c[FACE_RIGHT]  = ({1'b0, x_c} == w_use - SIZE_W'(1));
    edge_c[FACE_BOTTOM] = (y_c == '0);
    edge_c[FACE_TOP]    = ({1'b0, y_c} == h_use - SIZE_W'(1));
    edge_c[FACE_BACK]   = (z_c == '0);
    edge_c[FACE_FRONT]  = ({1'b0, z_c} == l_use - SIZE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ld) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_chan.command;
      s1_x_r    <= x_c;
      s1_y_r    <= y_c;
      s1_z_r    <= z_c;
      s1_id_r   <= in_chan.new_id;
      s1_edge_r <= edge_c;
    end
  end

  // grid read addresses: center, -x, +x, -y, +y, -z, +z, center again
  // neighbor addresses at the border wrap or fall outside the configured grid; the edge flag masks them
  logic [ADDR_W-1:0] rd_addr [RD_N];
  logic [ID_W-1:0]   rd_data [RD_N];
  logic [COORD_W-1:0] one_c;

  assign one_c = COORD_W'(1);

  always_comb begin
    rd_addr[0] = cell_addr(s1_x_r, s1_y_r, s1_z_r);
    rd_addr[1] = cell_addr(s1_x_r - one_c, s1_y_r, s1_z_r);
    rd_addr[2] = cell_addr(s1_x_r + one_c, s1_y_r, s1_z_r);
    rd_addr[3] = cell_addr(s1_x_r, s1_y_r - one_c, s1_z_r);
    rd_addr[4] = cell_addr(s1_x_r, s1_y_r + one_c, s1_z_r);
    rd_addr[5] = cell_addr(s1_x_r, s1_y_r, s1_z_r - one_c);
    rd_addr[6] = cell_addr(s1_x_r, s1_y_r, s1_z_r + one_c);
    rd_addr[7] = rd_addr[0];
  end

  ram_wr_t ram_wr;
  logic    rd_en;

  always_comb begin
    if (clearing_r) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_addr_r;
      ram_wr.data = (clr_y == '0) ? FLOOR_ID : '0;
    end else begin
      ram_wr.en   = s1_v_r && s2_ld && (s1_cmd_r == CMD_WRITE);
      ram_wr.addr = rd_addr[0];
      ram_wr.data = s1_id_r;
    end
  end

  assign rd_en = s1_v_r && s2_ld;

  for (genvar k = 0; k < RAM_N; k++) begin : g_copy
    vfv_grid_ram u_ram (
      .clk       (clk),
      .wr        (ram_wr),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr[2*k]),
      .rd_addr_b (rd_addr[2*k+1]),
      .rd_data_a (rd_data[2*k]),
      .rd_data_b (rd_data[2*k+1])
    );
  end

  // stage 2: grid data available
  logic              s2_cmd_r;
  logic [ID_W-1:0]   s2_id_r;
  logic [FACE_N-1:0] s2_edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ld) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_id_r   <= s1_id_r;
      s2_edge_r <= s1_edge_r;
    end
  end

  logic [ID_W-1:0]   held_nxt;
  logic [FACE_N-1:0] mask_nxt;
  logic [CNT_W-1:0]  count_nxt;

  always_comb begin
    held_nxt = (s2_cmd_r == CMD_WRITE) ? s2_id_r : rd_data[0];
    for (int b = 0; b < FACE_N; b++) begin
      mask_nxt[b] = (s2_cmd_r == CMD_QUERY) && (held_nxt != '0) &&
                    (s2_edge_r[b] || (rd_data[b+1] == '0));
    end
    count_nxt = '0;
    for (int b = 0; b < FACE_N; b++) begin
      count_nxt = count_nxt + CNT_W'(mask_nxt[b]);
    end
  end

  // result register
  logic [ID_W-1:0]   out_id_r;
  logic [FACE_N-1:0] out_mask_r;
  logic [CNT_W-1:0]  out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && s2_v_r) begin
      out_id_r    <= held_nxt;
      out_mask_r  <= mask_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.stored_id  = out_id_r;
  assign out_chan.face_mask  = out_mask_r;
  assign out_chan.face_count = out_count_r;

  `VFV_ASSERT_IMPLY(a_copies_agree, s2_v_r, rd_data[0] == rd_data[RD_N-1],
                    "grid copies disagree on the center cell")
  `VFV_ASSERT_IMPLY(a_clear_pipe_empty, clearing_r, !s1_v_r && !s2_v_r && !out_v_r,
                    "item in flight during clearing pass")
  `VFV_ASSERT_NEXT(a_clear_once, !clearing_r, !clearing_r,
                   "clearing pass restarted without reset")
  `VFV_ASSERT_IMPLY(a_empty_no_faces, out_v_r && (out_id_r == '0), out_mask_r == '0,
                    "empty cell reports exposed faces")

endmodule

// ===== hdl/vfv_grid_ram.sv =====
module vfv_grid_ram (
  input  logic                          clk,
  input  vfv_pkg::ram_wr_t              wr,
  input  logic                          rd_en,
  input  logic [vfv_pkg::ADDR_W-1:0]    rd_addr_a,
  input  logic [vfv_pkg::ADDR_W-1:0]    rd_addr_b,
  output logic [vfv_pkg::ID_W-1:0]      rd_data_a,
  output logic [vfv_pkg::ID_W-1:0]      rd_data_b
);
  import vfv_pkg::*;

  logic [ID_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
